// ===== hdl/rlfe_pkg.sv =====
// shared types, constants and colour functions for the rainbow led frame encoder
// no dependencies
package rlfe_pkg;

   localparam int unsigned CSR_INDEX_W   = 2;
   localparam int unsigned CSR_DATA_W    = 11;
   localparam int unsigned BRIGHT_W      = 9;
   localparam int unsigned HUE_W         = 8;
   localparam int unsigned COUNT_W       = 11;
   localparam int unsigned COLOUR_W      = 8;
   localparam int unsigned WORD_W        = 3 * COLOUR_W;
   localparam int unsigned SYMBOL_W      = 8;
   localparam int unsigned BIT_COUNT_W   = $clog2(WORD_W);
   localparam int unsigned QUEUE_DEPTH   = 4;
   localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_COUNT_W = QUEUE_PTR_W + 1;

   localparam logic [SYMBOL_W-1:0] SYM_ZERO    = 8'hC0;
   localparam logic [SYMBOL_W-1:0] SYM_ONE     = 8'hFC;
   localparam logic [HUE_W-1:0]    REGION_SPAN = 8'd43;
   localparam logic [COLOUR_W-1:0] FULL        = 8'hFF;
   localparam logic [BRIGHT_W-1:0] Q_ONE       = 9'd256;

   localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 9'd128;
   localparam logic [HUE_W-1:0]    SPEED_RESET  = 8'd2;
   localparam logic [HUE_W-1:0]    SPREAD_RESET = 8'd5;
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 11'd64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BRIGHTNESS = 2'd0,
      CSR_SPEED      = 2'd1,
      CSR_HUE_SPREAD = 2'd2,
      CSR_FRAME_LEDS = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BRIGHT_W-1:0] brightness;
      logic [HUE_W-1:0]    speed;
      logic [HUE_W-1:0]    hue_spread;
      logic [COUNT_W-1:0]  frame_leds;
   } cfg_type;

   typedef struct packed {
      logic [COLOUR_W-1:0] g;
      logic [COLOUR_W-1:0] r;
      logic [COLOUR_W-1:0] b;
   } rgb_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              frame_end;
   } led_type;

   // six-region hue wheel, full saturation and value
   function automatic rgb_type hue_to_rgb(input logic [HUE_W-1:0] hue);
      logic [2:0]          region;
      logic [HUE_W-1:0]    offset;
      logic [HUE_W-1:0]    rem;
      logic [COLOUR_W-1:0] up;
      logic [COLOUR_W-1:0] down;
      rgb_type             c;
      if (hue >= 8'(5 * REGION_SPAN)) begin
         region = 3'd5;
         offset = 8'(5 * REGION_SPAN);
      end else if (hue >= 8'(4 * REGION_SPAN)) begin
         region = 3'd4;
         offset = 8'(4 * REGION_SPAN);
      end else if (hue >= 8'(3 * REGION_SPAN)) begin
         region = 3'd3;
         offset = 8'(3 * REGION_SPAN);
      end else if (hue >= 8'(2 * REGION_SPAN)) begin
         region = 3'd2;
         offset = 8'(2 * REGION_SPAN);
      end else if (hue >= REGION_SPAN) begin
         region = 3'd1;
         offset = REGION_SPAN;
      end else begin
         region = 3'd0;
         offset = 8'd0;
      end
      rem  = hue - offset;
      // times six as two shifts, remainder never exceeds 42
      up   = 8'({rem, 2'b00} + {rem, 1'b0});
      down = FULL - up;
      case (region)
         3'd0: begin
            c.r = FULL; c.g = up;   c.b = 8'd0;
         end
         3'd1: begin
            c.r = down; c.g = FULL; c.b = 8'd0;
         end
         3'd2: begin
            c.r = 8'd0; c.g = FULL; c.b = up;
         end
         3'd3: begin
            c.r = 8'd0; c.g = down; c.b = FULL;
         end
         3'd4: begin
            c.r = up;   c.g = 8'd0; c.b = FULL;
         end
         default: begin
            c.r = FULL; c.g = 8'd0; c.b = down;
         end
      endcase
      return c;
   endfunction

   // q1.8 scale, truncated
   function automatic logic [COLOUR_W-1:0] scale_channel(input logic [COLOUR_W-1:0] raw,
                                                         input logic [BRIGHT_W-1:0] k);
      logic [COLOUR_W+BRIGHT_W-1:0] prod;
      prod = {{BRIGHT_W{1'b0}}, raw} * {{COLOUR_W{1'b0}}, k};
      return prod[COLOUR_W+7:8];
   endfunction

endpackage

// ===== hdl/rlfe_front.sv =====
// front end: takes requests, walks the frame position and hue, and builds the
// colour word over a short pipeline; depends on rlfe_pkg
module rlfe_front import rlfe_pkg::*; #(
   parameter int unsigned MAX_LEDS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_request,
   input  logic [QUEUE_COUNT_W-1:0] queue_count,
   output logic                     push_valid,
   output led_type                  push_data
);

   localparam int unsigned POS_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int unsigned EXT_W = (POS_W + 1 > COUNT_W) ? POS_W + 1 : COUNT_W;
   localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_LEDS);

   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [HUE_W-1:0]         hue_base_ff, hue_base_in;
   logic                     s1_valid_ff, s1_valid_in;
   logic [HUE_W-1:0]         s1_hue_ff;
   logic                     s1_end_ff;
   logic                     s2_valid_ff, s2_valid_in;
   rgb_type                  s2_raw_ff;
   logic                     s2_end_ff;

   logic [QUEUE_COUNT_W:0]   committed;
   logic                     accept_led;
   logic [EXT_W-1:0]         count_eff;
   logic [EXT_W-1:0]         pos_next;
   logic                     frame_end;
   logic [2*HUE_W-1:0]       step_prod;
   logic [HUE_W-1:0]         hue;
   logic [BRIGHT_W-1:0]      k;

   // credit check: queue entries plus everything still in the pipeline
   assign committed  = (QUEUE_COUNT_W+1)'(queue_count) + (QUEUE_COUNT_W+1)'(s1_valid_ff)
                     + (QUEUE_COUNT_W+1)'(s2_valid_ff);
   assign req_ready  = committed < (QUEUE_COUNT_W+1)'(QUEUE_DEPTH);
   assign accept_led = req_valid && req_ready && req_request;

   always_comb begin
      if (cfg.frame_leds == '0) begin
         count_eff = EXT_W'(1);
      end else if (EXT_W'(cfg.frame_leds) > MAX_EXT) begin
         count_eff = MAX_EXT;
      end else begin
         count_eff = EXT_W'(cfg.frame_leds);
      end
   end

   assign pos_next  = EXT_W'(pos_ff) + EXT_W'(1);
   assign frame_end = pos_next >= count_eff;
   assign step_prod = {{HUE_W{1'b0}}, HUE_W'(pos_ff)} * {{HUE_W{1'b0}}, cfg.hue_spread};
   assign hue       = hue_base_ff + step_prod[HUE_W-1:0];

   always_comb begin
      pos_in      = pos_ff;
      hue_base_in = hue_base_ff;
      if (accept_led) begin
         if (frame_end) begin
            pos_in      = '0;
            hue_base_in = hue_base_ff + cfg.speed;
         end else begin
            pos_in = pos_next[POS_W-1:0];
         end
      end
   end

   assign s1_valid_in = accept_led;
   assign s2_valid_in = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         hue_base_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         hue_base_ff <= hue_base_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_hue_ff <= hue;
      s1_end_ff <= frame_end;
      s2_raw_ff <= hue_to_rgb(s1_hue_ff);
      s2_end_ff <= s1_end_ff;
   end

   assign k = (cfg.brightness > Q_ONE) ? Q_ONE : cfg.brightness;

   assign push_valid          = s2_valid_ff;
   assign push_data.word      = {scale_channel(s2_raw_ff.g, k),
                                 scale_channel(s2_raw_ff.r, k),
                                 scale_channel(s2_raw_ff.b, k)};
   assign push_data.frame_end = s2_end_ff;

endmodule

// ===== hdl/rlfe_queue.sv =====
// short fifo of finished led words between the front and back ends
// depends on rlfe_pkg
module rlfe_queue import rlfe_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  led_type                  push_data,
   input  logic                     pop,
   output logic                     pop_valid,
   output led_type                  pop_data,
   output logic [QUEUE_COUNT_W-1:0] queue_count
);

   led_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_W-1:0] count_ff, count_in;

   // front end credit keeps pushes off a full queue
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_COUNT_W'(push_valid) - QUEUE_COUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid   = count_ff != '0;
   assign pop_data    = entry_ff[rd_ptr_ff];
   assign queue_count = count_ff;

endmodule

// ===== hdl/rlfe_back.sv =====
// back end: shifts each colour word out msb first, one symbol byte per bit
// depends on rlfe_pkg
module rlfe_back import rlfe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  led_type             pop_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SYMBOL_W-1:0] rsp_symbol_byte,
   output logic                rsp_last_of_led,
   output logic                rsp_last_of_frame
);

   localparam logic [BIT_COUNT_W-1:0] LAST_BIT = BIT_COUNT_W'(WORD_W - 1);

   logic                   active_ff, active_in;
   logic [WORD_W-1:0]      shift_ff, shift_in;
   logic [BIT_COUNT_W-1:0] bit_ff, bit_in;
   logic                   end_ff, end_in;
   logic                   sent;
   logic                   done;
   logic                   load;

   assign sent = active_ff && rsp_ready;
   assign done = sent && (bit_ff == LAST_BIT);
   // next led follows its predecessor with no gap when it is already waiting in the queue
   assign load = pop_valid && (!active_ff || done);
   assign pop  = load;

   always_comb begin
      active_in = active_ff;
      shift_in  = shift_ff;
      bit_in    = bit_ff;
      end_in    = end_ff;
      if (load) begin
         active_in = 1'b1;
         shift_in  = pop_data.word;
         bit_in    = '0;
         end_in    = pop_data.frame_end;
      end else if (done) begin
         active_in = 1'b0;
      end else if (sent) begin
         shift_in = {shift_ff[WORD_W-2:0], 1'b0};
         bit_in   = bit_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         bit_ff    <= '0;
      end else begin
         active_ff <= active_in;
         bit_ff    <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      end_ff   <= end_in;
   end

   assign rsp_valid         = active_ff;
   assign rsp_symbol_byte   = shift_ff[WORD_W-1] ? SYM_ONE : SYM_ZERO;
   assign rsp_last_of_led   = bit_ff == LAST_BIT;
   assign rsp_last_of_frame = (bit_ff == LAST_BIT) && end_ff;

endmodule

// ===== hdl/rainbow_led_frame_encoder.sv =====
// path of an led: front end stages s1 and s2, then the queue, then the back end shift register
// each led gives 24 symbol bytes, one per cycle while rsp_ready is high and the next led is
// waiting in the queue; the serialiser in the back end sets the sustained led rate
// up to four finished leds queue up, so requests are taken while symbols still drain
// reset (synchronous): frame position and hue base to zero, pipeline and queue empty,
// registers to brightness 128, speed 2, hue spread 5, led count 64
module rainbow_led_frame_encoder import rlfe_pkg::*; #(
   parameter int unsigned MAX_LEDS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_request,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SYMBOL_W-1:0]    rsp_symbol_byte,
   output logic                   rsp_last_of_led,
   output logic                   rsp_last_of_frame,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type                  cfg_ff, cfg_in;
   logic                     push_valid;
   led_type                  push_data;
   logic                     pop;
   logic                     pop_valid;
   led_type                  pop_data;
   logic [QUEUE_COUNT_W-1:0] queue_count;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_BRIGHTNESS: cfg_in.brightness = csr_write_data[BRIGHT_W-1:0];
            CSR_SPEED:      cfg_in.speed      = csr_write_data[HUE_W-1:0];
            CSR_HUE_SPREAD: cfg_in.hue_spread = csr_write_data[HUE_W-1:0];
            CSR_FRAME_LEDS: cfg_in.frame_leds = csr_write_data[COUNT_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brightness <= BRIGHT_RESET;
         cfg_ff.speed      <= SPEED_RESET;
         cfg_ff.hue_spread <= SPREAD_RESET;
         cfg_ff.frame_leds <= COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rlfe_front #(
      .MAX_LEDS(MAX_LEDS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_request (req_request),
      .queue_count (queue_count),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   rlfe_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_data   (push_data),
      .pop         (pop),
      .pop_valid   (pop_valid),
      .pop_data    (pop_data),
      .queue_count (queue_count)
   );

   rlfe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_data          (pop_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_symbol_byte   (rsp_symbol_byte),
      .rsp_last_of_led   (rsp_last_of_led),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

// ===== hdl/rlfe_checker.sv =====
// port-level checks on the rainbow led frame encoder, bound to the top level
// depends on rlfe_pkg and rainbow_led_frame_encoder
module rlfe_checker import rlfe_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_request,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SYMBOL_W-1:0]    rsp_symbol_byte,
   input logic                   rsp_last_of_led,
   input logic                   rsp_last_of_frame
);

   // stalled symbol holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol_byte)
         && $stable(rsp_last_of_led) && $stable(rsp_last_of_frame))
      else $error("stalled symbol changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_symbol_byte == SYM_ZERO || rsp_symbol_byte == SYM_ONE)
      else $error("symbol byte is neither zero nor one code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_frame |-> rsp_last_of_led)
      else $error("frame ended away from an led boundary");

   // a waiting request keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_request))
      else $error("waiting request changed");

   // after reset nothing is pending and requests are welcome
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("encoder not empty after reset");

endmodule

bind rainbow_led_frame_encoder rlfe_checker u_rlfe_checker (.*);
